@@ rtl/core/dcsr_pkg.sv @@
// shared types, codes and constants of the daisy-chain shadow refresh unit
package dcsr_pkg;

  localparam int MAX_DEVICES_DEF      = 8;
  localparam int PORTS_PER_DEVICE_DEF = 28;
  localparam int REGS_PER_DEVICE      = 4;

  localparam int IN_TDATA_W  = 16;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_DATA_W  = 4;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] CFG_DEVICE_COUNT = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ENABLED      = 1'd1;

  localparam logic [7:0] ADDR_NOP = 8'h00;
  localparam logic [7:0] ADDR_D0  = 8'h44;
  localparam logic [7:0] ADDR_D1  = 8'h4C;
  localparam logic [7:0] ADDR_D2  = 8'h54;
  localparam logic [7:0] ADDR_D3  = 8'h5C;

  typedef enum logic [1:0] {
    OP_SET   = 2'd0,
    OP_FLUSH = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOT_EN = 2'd1,
    ST_RANGE  = 2'd2,
    ST_RSVD   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_RD,
    S_MOD,
    S_FL_PRE,
    S_FL_EMIT,
    S_STATUS
  } state_t;

  typedef struct packed {
    logic       dirty;
    logic [7:0] shadow;
  } entry_t;

  typedef struct packed {
    logic   en;
    entry_t entry;
  } mem_wr_t;

  typedef struct packed {
    logic       is_status;
    logic [7:0] reg_address;
    logic [7:0] reg_data;
    logic       frame_end;
    status_t    status;
    logic       last;
  } out_item_t;

  function automatic logic [7:0] data_reg_addr(input logic [1:0] r);
    logic [7:0] a;
    case (r)
      2'd0:    a = ADDR_D0;
      2'd1:    a = ADDR_D1;
      2'd2:    a = ADDR_D2;
      default: a = ADDR_D3;
    endcase
    return a;
  endfunction

endpackage

@@ rtl/core/daisy_chain_shadow_refresh_unit.sv @@
// top level of the daisy-chain shadow refresh unit: configuration, store and sequencer
//
//  channel  | direction | handshake             | payload
//  in_      | slave     | in_tvalid/in_tready   | tuser operation, tdata port/level/defer
//  out_     | master    | out_tvalid/out_tready | tuser is_status, tdata pair/status, tlast
//  cfg_     | write     | cfg_we                | cfg_index, cfg_wdata
//
// one item at a time; the input is taken again once the status item is in the output register
// set: decode (S_DIV), read-modify-write (S_RD, S_MOD), then a flush unless deferred
// flush or clear: a prefetch step, then 4 * device_count pairs, one pair per cycle unless the output stalls
// each item ends with one status item; a stalled output holds the walk in place
// reset sets the device count to one and clears enable, control state and the store valid bits
module daisy_chain_shadow_refresh_unit #(
  parameter int MAX_DEVICES      = dcsr_pkg::MAX_DEVICES_DEF,
  parameter int PORTS_PER_DEVICE = dcsr_pkg::PORTS_PER_DEVICE_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [7:0] port, [8] level, [9] defer
  input  logic [dcsr_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [1:0] operation
  input  logic [dcsr_pkg::IN_TUSER_W-1:0]     in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [7:0] reg_address, [15:8] reg_data, [16] frame_end, [18:17] status
  output logic [dcsr_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // [0] is_status
  output logic                                out_tuser,
  output logic                                out_tlast,
  input  logic                                cfg_we,
  input  logic [dcsr_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [dcsr_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int DEPTH     = MAX_DEVICES * dcsr_pkg::REGS_PER_DEVICE;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int DEV_CNT_W = $clog2(MAX_DEVICES + 1);

  logic [3:0]           dev_count_r;
  logic                 enabled_r;
  logic [DEV_CNT_W-1:0] n_dev;
  logic [ADDR_W-1:0]    rd_addr;
  logic [ADDR_W-1:0]    wr_addr;
  dcsr_pkg::entry_t     rd_entry;
  dcsr_pkg::mem_wr_t    wr;
  dcsr_pkg::out_item_t  out_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_count_r <= 4'd1;
      enabled_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        dcsr_pkg::CFG_DEVICE_COUNT: dev_count_r <= cfg_wdata[3:0];
        dcsr_pkg::CFG_ENABLED:      enabled_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // saturate the chain length to the store size
  assign n_dev = (32'(dev_count_r) > MAX_DEVICES) ? DEV_CNT_W'(MAX_DEVICES)
                                                 : DEV_CNT_W'(dev_count_r);

  dcsr_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry),
    .wr       (wr),
    .wr_addr  (wr_addr)
  );

  dcsr_ctrl #(
    .MAX_DEVICES      (MAX_DEVICES),
    .PORTS_PER_DEVICE (PORTS_PER_DEVICE),
    .DEPTH            (DEPTH),
    .ADDR_W           (ADDR_W),
    .DEV_CNT_W        (DEV_CNT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (in_tuser[1:0]),
    .in_port   (in_tdata[7:0]),
    .in_level  (in_tdata[8]),
    .in_defer  (in_tdata[9]),
    .enabled   (enabled_r),
    .n_dev     (n_dev),
    .rd_addr   (rd_addr),
    .rd_entry  (rd_entry),
    .wr        (wr),
    .wr_addr   (wr_addr),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_item  (out_item)
  );

  assign out_tdata = {5'd0, out_item.status, out_item.frame_end,
                      out_item.reg_data, out_item.reg_address};
  assign out_tuser = out_item.is_status;
  assign out_tlast = out_item.last;

endmodule

@@ rtl/core/dcsr_mem.sv @@
// shadow byte and dirty mark store with per-entry valid bits and registered read
module dcsr_mem #(
  parameter int DEPTH  = dcsr_pkg::MAX_DEVICES_DEF * dcsr_pkg::REGS_PER_DEVICE,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [ADDR_W-1:0]  rd_addr,
  output dcsr_pkg::entry_t   rd_entry,
  input  dcsr_pkg::mem_wr_t  wr,
  input  logic [ADDR_W-1:0]  wr_addr
);

  dcsr_pkg::entry_t mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  dcsr_pkg::entry_t rd_data_r;
  logic             rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr] <= wr.entry;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr.en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  // entries never written read as the reset value
  assign rd_entry = rd_vld_r ? rd_data_r : '0;

endmodule

@@ rtl/core/dcsr_ctrl.sv @@
// sequencer: port decode, read-modify-write of the store, frame walk and result register
module dcsr_ctrl #(
  parameter int MAX_DEVICES      = dcsr_pkg::MAX_DEVICES_DEF,
  parameter int PORTS_PER_DEVICE = dcsr_pkg::PORTS_PER_DEVICE_DEF,
  parameter int DEPTH            = MAX_DEVICES * dcsr_pkg::REGS_PER_DEVICE,
  parameter int ADDR_W           = $clog2(DEPTH),
  parameter int DEV_CNT_W        = $clog2(MAX_DEVICES + 1)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_op,
  input  logic [7:0]              in_port,
  input  logic                    in_level,
  input  logic                    in_defer,
  input  logic                    enabled,
  input  logic [DEV_CNT_W-1:0]    n_dev,
  output logic [ADDR_W-1:0]       rd_addr,
  input  dcsr_pkg::entry_t        rd_entry,
  output dcsr_pkg::mem_wr_t       wr,
  output logic [ADDR_W-1:0]       wr_addr,
  output logic                    out_valid,
  input  logic                    out_ready,
  output dcsr_pkg::out_item_t     out_item
);

  localparam int         DIV_W   = $clog2(256 / PORTS_PER_DEVICE + 1);
  localparam logic [7:0] PPD     = 8'(PORTS_PER_DEVICE);
  localparam int         DIV_SH  = 8 + $clog2(PORTS_PER_DEVICE);
  localparam int         DIV_MUL = (2 ** DIV_SH + PORTS_PER_DEVICE - 1) / PORTS_PER_DEVICE;
  localparam int         MUL_W   = $clog2(DIV_MUL + 1);
  localparam int         PROD_W  = 8 + MUL_W;

  dcsr_pkg::state_t    state_r, state_nxt;
  logic [7:0]          rem_r, rem_nxt;
  logic [DIV_W-1:0]    div_dev_r, div_dev_nxt;
  logic                level_r, level_nxt;
  logic                defer_r, defer_nxt;
  logic                clear_r, clear_nxt;
  dcsr_pkg::status_t   status_r, status_nxt;
  logic [DEV_CNT_W-1:0] walk_dev_r, walk_dev_nxt;
  logic [1:0]          walk_reg_r, walk_reg_nxt;
  logic                out_valid_r, out_valid_nxt;
  dcsr_pkg::out_item_t out_item_r, out_item_nxt;

  logic                 can_emit;
  logic [ADDR_W-1:0]    set_idx;
  logic [ADDR_W-1:0]    walk_idx;
  logic [ADDR_W-1:0]    adv_idx;
  logic                 last_dev;
  logic                 walk_done;
  logic [DEV_CNT_W-1:0] walk_dev_adv;
  logic [1:0]           walk_reg_adv;
  logic [7:0]           set_mask;
  logic                 send;
  logic [7:0]           shadow_eff;
  logic [PROD_W-1:0]    div_prod;
  logic [DIV_W-1:0]     div_q;
  logic [7:0]           div_r;

  assign can_emit     = !out_valid_r || out_ready;
  assign set_idx      = ADDR_W'({div_dev_r, rem_r[4:3]});
  assign walk_idx     = ADDR_W'({walk_dev_r, walk_reg_r});
  assign last_dev     = (walk_dev_r == n_dev - DEV_CNT_W'(1));
  assign walk_done    = last_dev && (walk_reg_r == 2'd3);
  assign walk_dev_adv = last_dev ? '0 : walk_dev_r + DEV_CNT_W'(1);
  assign walk_reg_adv = last_dev ? walk_reg_r + 2'd1 : walk_reg_r;
  assign adv_idx      = ADDR_W'({walk_dev_adv, walk_reg_adv});
  assign set_mask     = 8'd1 << rem_r[2:0];
  assign send         = clear_r || rd_entry.dirty;
  assign shadow_eff   = clear_r ? 8'd0 : rd_entry.shadow;
  assign div_prod     = PROD_W'(rem_r) * PROD_W'(DIV_MUL);
  assign div_q        = DIV_W'(div_prod >> DIV_SH);
  assign div_r        = rem_r - 8'(div_q) * PPD;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dcsr_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r      <= rem_nxt;
    div_dev_r  <= div_dev_nxt;
    level_r    <= level_nxt;
    defer_r    <= defer_nxt;
    clear_r    <= clear_nxt;
    status_r   <= status_nxt;
    walk_dev_r <= walk_dev_nxt;
    walk_reg_r <= walk_reg_nxt;
    out_item_r <= out_item_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    rem_nxt       = rem_r;
    div_dev_nxt   = div_dev_r;
    level_nxt     = level_r;
    defer_nxt     = defer_r;
    clear_nxt     = clear_r;
    status_nxt    = status_r;
    walk_dev_nxt  = walk_dev_r;
    walk_reg_nxt  = walk_reg_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_item_nxt  = out_item_r;
    in_ready      = 1'b0;
    rd_addr       = walk_idx;
    wr            = '0;
    wr_addr       = walk_idx;

    case (state_r)
      dcsr_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          rem_nxt      = in_port;
          div_dev_nxt  = '0;
          level_nxt    = in_level;
          defer_nxt    = in_defer;
          clear_nxt    = (in_op == dcsr_pkg::OP_CLEAR);
          status_nxt   = dcsr_pkg::ST_OK;
          walk_dev_nxt = '0;
          walk_reg_nxt = 2'd0;
          if (!enabled) begin
            status_nxt = dcsr_pkg::ST_NOT_EN;
            state_nxt  = dcsr_pkg::S_STATUS;
          end else begin
            case (in_op)
              dcsr_pkg::OP_SET:   state_nxt = dcsr_pkg::S_DIV;
              dcsr_pkg::OP_FLUSH: state_nxt = dcsr_pkg::S_FL_PRE;
              dcsr_pkg::OP_CLEAR: state_nxt = dcsr_pkg::S_FL_PRE;
              default:            state_nxt = dcsr_pkg::S_STATUS;
            endcase
          end
        end
      end
      // port / ports_per_device by reciprocal multiplication
      dcsr_pkg::S_DIV: begin
        rem_nxt     = div_r;
        div_dev_nxt = div_q;
        if (8'(div_q) >= 8'(n_dev)) begin
          status_nxt = dcsr_pkg::ST_RANGE;
          state_nxt  = dcsr_pkg::S_STATUS;
        end else begin
          state_nxt = dcsr_pkg::S_RD;
        end
      end
      dcsr_pkg::S_RD: begin
        rd_addr   = set_idx;
        state_nxt = dcsr_pkg::S_MOD;
      end
      dcsr_pkg::S_MOD: begin
        wr.en           = 1'b1;
        wr.entry.dirty  = 1'b1;
        wr.entry.shadow = level_r ? (rd_entry.shadow | set_mask)
                                  : (rd_entry.shadow & ~set_mask);
        wr_addr         = set_idx;
        state_nxt       = defer_r ? dcsr_pkg::S_STATUS : dcsr_pkg::S_FL_PRE;
      end
      dcsr_pkg::S_FL_PRE: begin
        if (n_dev == '0) begin
          state_nxt = dcsr_pkg::S_STATUS;
        end else begin
          state_nxt = dcsr_pkg::S_FL_EMIT;
        end
      end
      dcsr_pkg::S_FL_EMIT: begin
        if (can_emit) begin
          out_valid_nxt            = 1'b1;
          out_item_nxt.is_status   = 1'b0;
          out_item_nxt.reg_address = send ? dcsr_pkg::data_reg_addr(walk_reg_r)
                                          : dcsr_pkg::ADDR_NOP;
          out_item_nxt.reg_data    = send ? shadow_eff : 8'd0;
          out_item_nxt.frame_end   = last_dev;
          out_item_nxt.status      = dcsr_pkg::ST_OK;
          out_item_nxt.last        = 1'b0;
          wr.en                    = send;
          wr.entry.dirty           = 1'b0;
          wr.entry.shadow          = shadow_eff;
          walk_dev_nxt             = walk_dev_adv;
          walk_reg_nxt             = walk_reg_adv;
          rd_addr                  = adv_idx;
          if (walk_done) begin
            state_nxt = dcsr_pkg::S_STATUS;
          end
        end
      end
      dcsr_pkg::S_STATUS: begin
        if (can_emit) begin
          out_valid_nxt            = 1'b1;
          out_item_nxt.is_status   = 1'b1;
          out_item_nxt.reg_address = dcsr_pkg::ADDR_NOP;
          out_item_nxt.reg_data    = 8'd0;
          out_item_nxt.frame_end   = 1'b0;
          out_item_nxt.status      = status_r;
          out_item_nxt.last        = 1'b1;
          state_nxt                = dcsr_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = dcsr_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef SYNTH
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> (state_r == dcsr_pkg::S_MOD || state_r == dcsr_pkg::S_FL_EMIT))
    else $error("store written outside a modify or flush step");

  a_walk_in_chain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dcsr_pkg::S_FL_EMIT) |-> (walk_dev_r < n_dev))
    else $error("frame walk beyond the chained devices");

  a_last_is_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_item_r.last == out_item_r.is_status))
    else $error("last flag not on the status item");

  a_disabled_status: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dcsr_pkg::S_IDLE && in_valid && !enabled)
      |=> (state_r == dcsr_pkg::S_STATUS && status_r == dcsr_pkg::ST_NOT_EN))
    else $error("disabled operation not answered by a status item");
`endif

endmodule

@@ sim/tb.sv @@
// self-checking testbench of the daisy-chain shadow refresh unit over its stream ports
`timescale 1ns / 100ps

module tb;
  import dcsr_pkg::*;

  localparam int TIMEOUT_CYCLES = 600000;
  localparam int SETTLE_CYCLES  = 60;
  localparam int LONG_STALL     = 400;
  localparam int N_ENTRIES      = MAX_DEVICES_DEF * REGS_PER_DEVICE;

  typedef struct {
    op_t        op;
    logic [7:0] port;
    logic       level;
    logic       defer;
    bit         drain_first;
  } stim_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [IN_TUSER_W-1:0]  in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tlast;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  daisy_chain_shadow_refresh_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // shadow copy of the expander registers
  logic [7:0] shadow_m [N_ENTRIES];
  bit         dirty_m [N_ENTRIES];
  logic [3:0] dev_count_m = 4'd1;
  bit         enabled_m = 1'b0;
  logic [7:0] addr_tab [REGS_PER_DEVICE] = '{ADDR_D0, ADDR_D1, ADDR_D2, ADDR_D3};

  stim_t      pending_items[$];
  out_item_t  expected_items[$];
  stim_t      cur_item;
  out_item_t  want_item;

  int snd_idle_pct = 8;
  int rcv_idle_pct = 63;
  int stall_req = 0;
  int stall_ack = 0;
  int stall_left = 0;
  int err_cnt = 0;
  int n_in = 0;
  int n_out = 0;
  int cycles = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int chain_len();
    return (dev_count_m > MAX_DEVICES_DEF) ? MAX_DEVICES_DEF : int'(dev_count_m);
  endfunction

  function automatic out_item_t pair_item(logic [7:0] a, logic [7:0] d, logic fend);
    out_item_t o;
    o.is_status   = 1'b0;
    o.reg_address = a;
    o.reg_data    = d;
    o.frame_end   = fend;
    o.status      = ST_OK;
    o.last        = 1'b0;
    return o;
  endfunction

  function automatic out_item_t status_item(status_t st);
    out_item_t o;
    o.is_status   = 1'b1;
    o.reg_address = ADDR_NOP;
    o.reg_data    = 8'h00;
    o.frame_end   = 1'b0;
    o.status      = st;
    o.last        = 1'b1;
    return o;
  endfunction

  task automatic refresh_frames(input bit clear_all);
    int n;
    int idx;
    logic fend;
    n = chain_len();
    for (int ri = 0; ri < REGS_PER_DEVICE; ri++) begin
      for (int d = 0; d < n; d++) begin
        idx  = d * REGS_PER_DEVICE + ri;
        fend = (d == n - 1);
        if (clear_all) shadow_m[idx] = 8'h00;
        if (clear_all || dirty_m[idx]) begin
          expected_items.push_back(pair_item(addr_tab[ri], shadow_m[idx], fend));
          dirty_m[idx] = 1'b0;
        end else begin
          expected_items.push_back(pair_item(ADDR_NOP, 8'h00, fend));
        end
      end
    end
  endtask

  task automatic predict_refresh(input stim_t s);
    int dev;
    int pos;
    int idx;
    if (!enabled_m) begin
      expected_items.push_back(status_item(ST_NOT_EN));
      return;
    end
    case (s.op)
      OP_SET: begin
        dev = int'(s.port) / PORTS_PER_DEVICE_DEF;
        pos = int'(s.port) % PORTS_PER_DEVICE_DEF;
        if (dev >= chain_len()) begin
          expected_items.push_back(status_item(ST_RANGE));
          return;
        end
        idx = dev * REGS_PER_DEVICE + ((pos >> 3) & 3);
        shadow_m[idx][pos & 7] = s.level;
        dirty_m[idx] = 1'b1;
        if (!s.defer) refresh_frames(1'b0);
      end
      OP_FLUSH: refresh_frames(1'b0);
      OP_CLEAR: refresh_frames(1'b1);
      default: ;
    endcase
    expected_items.push_back(status_item(ST_OK));
  endtask

  task automatic report(input string what, input int got, input int want);
    err_cnt++;
    if (err_cnt <= 40)
      $display("mismatch at cycle %0d: %s got %0h want %0h", cycles, what, got, want);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_refresh(cur_item);
        n_in++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_items.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct &&
            !(pending_items[0].drain_first && expected_items.size() != 0)) begin
          cur_item  = pending_items.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= cur_item.op;
          in_tdata  <= {6'b0, cur_item.defer, cur_item.level, cur_item.port};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver with random back-pressure and one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_ack != stall_req) begin
      stall_ack  <= stall_req;
      stall_left <= LONG_STALL;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      n_out++;
      if (expected_items.size() == 0) begin
        report("unexpected item", int'(out_tdata), 0);
      end else begin
        want_item = expected_items.pop_front();
        if (out_tuser !== want_item.is_status)
          report("is_status", int'(out_tuser), int'(want_item.is_status));
        if (out_tdata[7:0] !== want_item.reg_address)
          report("reg_address", int'(out_tdata[7:0]), int'(want_item.reg_address));
        if (out_tdata[15:8] !== want_item.reg_data)
          report("reg_data", int'(out_tdata[15:8]), int'(want_item.reg_data));
        if (out_tdata[16] !== want_item.frame_end)
          report("frame_end", int'(out_tdata[16]), int'(want_item.frame_end));
        if (out_tdata[18:17] !== want_item.status)
          report("status", int'(out_tdata[18:17]), int'(want_item.status));
        if (out_tlast !== want_item.last)
          report("last", int'(out_tlast), int'(want_item.last));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > TIMEOUT_CYCLES) begin
      $display("timeout with %0d items still expected", expected_items.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic push_item(input op_t op, input int port, input bit level, input bit defer,
                           input bit drain_first = 1'b0);
    stim_t s;
    s.op          = op;
    s.port        = port[7:0];
    s.level       = level;
    s.defer       = defer;
    s.drain_first = drain_first;
    pending_items.push_back(s);
  endtask

  task automatic push_random(input int count, input int drain_every);
    int n;
    int r;
    int port;
    op_t op;
    n = chain_len();
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 60)      op = OP_SET;
      else if (r < 80) op = OP_FLUSH;
      else if (r < 92) op = OP_CLEAR;
      else             op = OP_NOP;
      if (n > 0 && $urandom_range(0, 9) < 8)
        port = $urandom_range(0, n * PORTS_PER_DEVICE_DEF - 1);
      else
        port = $urandom_range(0, 255);
      push_item(op, port, bit'($urandom_range(0, 1)), bit'($urandom_range(0, 1)),
                drain_every > 0 && (i % drain_every) == drain_every - 1);
    end
  endtask

  task automatic wait_idle();
    while (pending_items.size() != 0 || in_tvalid || expected_items.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_config(input int dev_count, input bit en);
    wait_idle();
    cfg_write(CFG_DEVICE_COUNT, dev_count[3:0]);
    cfg_write(CFG_ENABLED, {3'b000, en});
    dev_count_m = dev_count[3:0];
    enabled_m   = en;
    @(negedge clk);
  endtask

  initial begin
    for (int i = 0; i < N_ENTRIES; i++) begin
      shadow_m[i] = 8'h00;
      dirty_m[i]  = 1'b0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset defaults: one device, not enabled
    push_item(OP_SET, 0, 1'b1, 1'b0);
    push_item(OP_FLUSH, 0, 1'b0, 1'b0);
    push_item(OP_CLEAR, 0, 1'b0, 1'b0);
    push_item(OP_NOP, 255, 1'b1, 1'b1);

    set_config(1, 1'b1);
    push_item(OP_SET, 0, 1'b1, 1'b0);
    push_item(OP_SET, 27, 1'b1, 1'b1);
    push_item(OP_SET, 28, 1'b1, 1'b0);
    push_item(OP_SET, 255, 1'b1, 1'b0);
    push_item(OP_FLUSH, 0, 1'b0, 1'b0);
    push_item(OP_SET, 8, 1'b1, 1'b1);
    push_item(OP_SET, 8, 1'b0, 1'b0);
    push_item(OP_CLEAR, 0, 1'b0, 1'b0);
    push_item(OP_NOP, 0, 1'b0, 1'b0);
    push_item(OP_FLUSH, 0, 1'b0, 1'b0);

    set_config(8, 1'b1);
    push_item(OP_SET, 223, 1'b1, 1'b0);
    push_item(OP_SET, 224, 1'b1, 1'b0);
    push_item(OP_SET, 200, 1'b1, 1'b1);

    // device 7 stays dirty while the chain is short
    set_config(2, 1'b1);
    push_item(OP_FLUSH, 0, 1'b0, 1'b0);
    set_config(8, 1'b1);
    push_item(OP_FLUSH, 0, 1'b0, 1'b0);
    push_item(OP_CLEAR, 0, 1'b0, 1'b0);

    set_config(0, 1'b1);
    push_item(OP_SET, 0, 1'b1, 1'b0);
    push_item(OP_FLUSH, 0, 1'b0, 1'b0);
    push_item(OP_CLEAR, 0, 1'b0, 1'b0);

    set_config(15, 1'b1);
    push_item(OP_SET, 223, 1'b1, 1'b1);
    push_item(OP_SET, 224, 1'b1, 1'b0);
    push_item(OP_FLUSH, 0, 1'b0, 1'b0);

    set_config(8, 1'b0);
    push_item(OP_SET, 1, 1'b1, 1'b0);
    set_config(8, 1'b1);
    push_item(OP_FLUSH, 0, 1'b0, 1'b0);

    set_config($urandom_range(1, 8), 1'b1);
    push_random(34, 0);

    set_config($urandom_range(1, 15), 1'b1);
    snd_idle_pct = 63;
    rcv_idle_pct = 8;
    push_random(34, 0);

    set_config(8, 1'b1);
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    stall_req++;
    push_random(34, 15);

    wait_idle();
    $display("ran %0d items with %0d results across device counts 0 to 15,", n_in, n_out);
    $display("all operations, disabled mode, three idling mixes and a long output hold-off");
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
